// ===== design/ndce_pkg.sv =====
// ndce_pkg: request/response payload types and CORDIC angle constants
// for the normal direction color encoder. No dependencies.
package ndce_pkg;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [7:0]         mask_value;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   localparam int CORDIC_STEPS = 30;
   localparam int CW = 44;
   localparam logic [31:0] GAIN_Q16 = 32'd107922;

   typedef logic signed [CW-1:0] cval_type;

   typedef struct packed {
      logic        pixel_ok;
      logic        y_pos;
      logic        y_neg;
      logic        x_neg;
      logic        all_zero;
   } flags_type;

   function automatic logic [31:0] atan_turn32(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== design/ndce_cordic_stage.sv =====
// ndce_cordic_stage: one registered CORDIC vectoring micro-rotation.
// Depends on ndce_pkg.
module ndce_cordic_stage
   import ndce_pkg::*;
#(
   parameter int STEP = 0,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  cval_type         in_x,
   input  cval_type         in_y,
   input  logic signed [33:0] in_acc,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output cval_type         out_x,
   output cval_type         out_y,
   output logic signed [33:0] out_acc,
   output logic [TAG_W-1:0] out_tag
);
   cval_type x_in, y_in;
   logic signed [33:0] acc_in;
   cval_type x_ff, y_ff;
   logic signed [33:0] acc_ff;
   logic [TAG_W-1:0] tag_ff;
   logic valid_ff;
   logic signed [33:0] ang;

   always_comb begin
      ang = $signed({2'b00, atan_turn32(5'(STEP))});
      if (in_y > 0) begin
         x_in = in_x + (in_y >>> STEP);
         y_in = in_y - (in_x >>> STEP);
         acc_in = in_acc + ang;
      end else begin
         x_in = in_x - (in_y >>> STEP);
         y_in = in_y + (in_x >>> STEP);
         acc_in = in_acc - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (adv) valid_ff <= in_valid;
      if (adv) begin
         x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_acc = acc_ff;
   assign out_tag = tag_ff;
endmodule

// ===== design/ndce_cordic_pipe.sv =====
// ndce_cordic_pipe: 30-stage pipelined CORDIC vectoring unit.
// Depends on ndce_pkg and ndce_cordic_stage.
module ndce_cordic_pipe
   import ndce_pkg::*;
#(
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  cval_type         in_x,
   input  cval_type         in_y,
   input  logic signed [33:0] in_acc,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output cval_type         out_x,
   output cval_type         out_y,
   output logic signed [33:0] out_acc,
   output logic [TAG_W-1:0] out_tag
);
   logic             v [CORDIC_STEPS+1];
   cval_type         xs [CORDIC_STEPS+1];
   cval_type         ys [CORDIC_STEPS+1];
   logic signed [33:0] as [CORDIC_STEPS+1];
   logic [TAG_W-1:0] ts [CORDIC_STEPS+1];

   assign v[0] = in_valid;
   assign xs[0] = in_x;
   assign ys[0] = in_y;
   assign as[0] = in_acc;
   assign ts[0] = in_tag;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_stage
      ndce_cordic_stage #(.STEP(g), .TAG_W(TAG_W)) u_stage (
         .clock, .reset, .adv,
         .in_valid(v[g]), .in_x(xs[g]), .in_y(ys[g]), .in_acc(as[g]), .in_tag(ts[g]),
         .out_valid(v[g+1]), .out_x(xs[g+1]), .out_y(ys[g+1]),
         .out_acc(as[g+1]), .out_tag(ts[g+1])
      );
   end

   assign out_valid = v[CORDIC_STEPS];
   assign out_x = xs[CORDIC_STEPS];
   assign out_y = ys[CORDIC_STEPS];
   assign out_acc = as[CORDIC_STEPS];
   assign out_tag = ts[CORDIC_STEPS];
endmodule

// ===== design/normal_direction_color_encoder.sv =====
// Normal direction color encoder: one request per cycle unless the response
// is stalled. Two chained 30-stage CORDIC pipelines (hue, elevation) then
// ROM interpolation and blend stages; one global advance freezes all stages.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
// Depends on ndce_pkg, ndce_cordic_pipe.
module normal_direction_color_encoder
   import ndce_pkg::*;
#(
   parameter int NUM_COLORS = 64,
   parameter int HUE_OFFSET_STEPS = 0,
   parameter int ANGLE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int A = ANGLE_BITS;
   localparam int IW = A + 1;
   localparam int NW = $clog2(NUM_COLORS);
   localparam int AQW = IW + NW;
   localparam int ZW = 16;
   localparam int HTAG = 16 + 5;
   localparam int ETAG = IW + 5;

   function automatic logic [23:0] rom_entry(input int i);
      int pos, six, sector, rem, up, dn, r, g, b;
      pos = (i + HUE_OFFSET_STEPS) % NUM_COLORS;
      six = 6 * pos;
      sector = six / NUM_COLORS;
      rem = six % NUM_COLORS;
      up = (510 * rem + NUM_COLORS) / (2 * NUM_COLORS);
      dn = (510 * (NUM_COLORS - rem) + NUM_COLORS) / (2 * NUM_COLORS);
      unique case (sector)
         0: begin r = 255; g = up; b = 0; end
         1: begin r = dn; g = 255; b = 0; end
         2: begin r = 0; g = 255; b = up; end
         3: begin r = 0; g = dn; b = 255; end
         4: begin r = up; g = 0; b = 255; end
         default: begin r = 255; g = 0; b = dn; end
      endcase
      return {8'(r), 8'(g), 8'(b)};
   endfunction

   logic [23:0] rom [NUM_COLORS];
   for (genvar k = 0; k < NUM_COLORS; k++) begin : g_rom
      assign rom[k] = rom_entry(k);
   end

   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 0: prerotate
   logic      s0_valid_ff;
   cval_type  s0_x_ff, s0_y_ff;
   logic signed [33:0] s0_acc_ff;
   logic [HTAG-1:0] s0_tag_ff;
   flags_type f0;
   cval_type  cx0, cy0;
   logic signed [33:0] acc0;

   always_comb begin
      f0.pixel_ok = req_data.mask_value[7];
      f0.y_pos = req_data.normal_y > 0;
      f0.y_neg = req_data.normal_y < 0;
      f0.x_neg = req_data.normal_x < 0;
      f0.all_zero = (req_data.normal_x == 0) && (req_data.normal_y == 0)
                  && (req_data.normal_z == 0);
      cx0 = CW'(req_data.normal_x) <<< 8;
      cy0 = CW'(req_data.normal_y) <<< 8;
      acc0 = '0;
      if (f0.x_neg) begin
         acc0 = f0.y_neg ? -34'sh80000000 : 34'sh80000000;
         cx0 = -cx0;
         cy0 = -cy0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (adv) s0_valid_ff <= req_valid;
      if (adv) begin
         s0_x_ff <= cx0; s0_y_ff <= cy0; s0_acc_ff <= acc0;
         s0_tag_ff <= {req_data.normal_z, f0};
      end
   end

   logic h_valid;
   cval_type h_x, h_y;
   logic signed [33:0] h_acc;
   logic [HTAG-1:0] h_tag;

   ndce_cordic_pipe #(.TAG_W(HTAG)) u_hue (
      .clock, .reset, .adv,
      .in_valid(s0_valid_ff), .in_x(s0_x_ff), .in_y(s0_y_ff),
      .in_acc(s0_acc_ff), .in_tag(s0_tag_ff),
      .out_valid(h_valid), .out_x(h_x), .out_y(h_y), .out_acc(h_acc), .out_tag(h_tag)
   );

   // stage: hue angle, z gain multiply
   flags_type fh;
   logic signed [ZW-1:0] zh;
   logic signed [33:0] th;
   logic signed [33:0] half_s;
   logic [IW-1:0] idx_h;
   logic signed [49:0] zg;
   logic s1_valid_ff;
   cval_type s1_x_ff, s1_y_ff;
   logic [ETAG-1:0] s1_tag_ff;

   always_comb begin
      fh = h_tag[4:0];
      zh = h_tag[HTAG-1:5];
      half_s = 34'sd1 <<< (A - 1);
      th = (h_acc + (34'sd1 <<< (31 - A))) >>> (32 - A);
      if (fh.y_pos) begin
         if (th < 0) th = '0;
         if (th > half_s) th = half_s;
      end else if (fh.y_neg) begin
         if (th > 0) th = '0;
         if (th < -half_s) th = -half_s;
      end else begin
         th = fh.x_neg ? half_s : '0;
      end
      idx_h = IW'(th + half_s);
      zg = 50'(zh) * $signed({1'b0, GAIN_Q16[17:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= h_valid;
      if (adv) begin
         s1_x_ff <= h_x;
         s1_y_ff <= CW'(zg >>> 8);
         s1_tag_ff <= {idx_h, fh};
      end
   end

   logic e_valid;
   cval_type e_x, e_y;
   logic signed [33:0] e_acc;
   logic [ETAG-1:0] e_tag;

   ndce_cordic_pipe #(.TAG_W(ETAG)) u_elev (
      .clock, .reset, .adv,
      .in_valid(s1_valid_ff), .in_x(s1_x_ff), .in_y(s1_y_ff),
      .in_acc('0), .in_tag(s1_tag_ff),
      .out_valid(e_valid), .out_x(e_x), .out_y(e_y), .out_acc(e_acc), .out_tag(e_tag)
   );

   // stage: saturation and address multiply
   flags_type fe;
   logic signed [33:0] phi, quarter_s;
   logic [IW-1:0] sat_e;
   logic [AQW-1:0] aq;
   logic s2_valid_ff;
   logic [IW-1:0] s2_sat_ff;
   logic [AQW-1:0] s2_aq_ff;
   logic s2_ok_ff;

   always_comb begin
      fe = e_tag[4:0];
      quarter_s = 34'sd1 <<< (A - 2);
      phi = (e_acc + (34'sd1 <<< (31 - A))) >>> (32 - A);
      if (phi > quarter_s) phi = quarter_s;
      if (phi < -quarter_s) phi = -quarter_s;
      if (fe.all_zero) phi = '0;
      sat_e = IW'((34'sd1 <<< (A - 1)) + 2 * phi);
      aq = AQW'(e_tag[ETAG-1:5]) * AQW'(NUM_COLORS - 2);
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= e_valid;
      if (adv) begin
         s2_sat_ff <= sat_e; s2_aq_ff <= aq; s2_ok_ff <= fe.pixel_ok;
      end
   end

   // stage: ROM read
   logic [NW-1:0] ai;
   logic [A-1:0] w3;
   logic s3_valid_ff, s3_ok_ff;
   logic [23:0] s3_e0_ff, s3_e1_ff;
   logic [A-1:0] s3_w_ff;
   logic [IW-1:0] s3_sat_ff;

   always_comb begin
      w3 = s2_aq_ff[A-1:0];
      if (s2_aq_ff[AQW-1:A] > (AQW-A)'(NUM_COLORS - 2)) begin
         ai = NW'(NUM_COLORS - 2);
         w3 = '0;
      end else begin
         ai = s2_aq_ff[A+NW-1:A];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
      if (adv) begin
         s3_e0_ff <= rom[ai]; s3_e1_ff <= rom[ai + NW'(1)];
         s3_w_ff <= w3; s3_sat_ff <= s2_sat_ff; s3_ok_ff <= s2_ok_ff;
      end
   end

   // stage: interpolate
   logic [7:0] ci [3];
   logic s4_valid_ff, s4_ok_ff;
   logic [7:0] s4_c_ff [3];
   logic [IW-1:0] s4_sat_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ci[k] = 8'((({1'b0, ~s3_w_ff} + (A+1)'(1)) * (A+9)'(s3_e0_ff[8*k +: 8])
                   + (A+9)'(s3_w_ff) * (A+9)'(s3_e1_ff[8*k +: 8])
                   + (A+9)'(1 << (A - 1))) >> A);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
      if (adv) begin
         s4_c_ff <= ci; s4_sat_ff <= s3_sat_ff; s4_ok_ff <= s3_ok_ff;
      end
   end

   // stage: blend toward white
   rsp_type out_in;
   logic [7:0] bo [3];
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         bo[k] = 8'(((A+10)'(511) * (A+10)'(1 << (A - 1))
                   - (A+10)'(s4_sat_ff) * (A+10)'(8'd255 - s4_c_ff[k])) >> A);
         if (!s4_ok_ff) bo[k] = '0;
      end
      out_in.red = bo[2];
      out_in.green = bo[1];
      out_in.blue = bo[0];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= s4_valid_ff;
      if (adv) rsp_data_ff <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("stall not tied to output backpressure");
   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !s4_ok_ff && adv |=> rsp_data == '0)
      else $error("masked pixel not black");
endmodule
